// ===== src/swah_pkg.sv =====
// Shared types, sizes and codes for the sliding-window ADC histogram.
// No dependencies; every other file of the block but swah_ram imports this package.
package swah_pkg;

  localparam int NUM_BINS   = 64;
  localparam int MAX_WINDOW = 16;

  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SLOT_DEPTH = MAX_WINDOW * NUM_BINS;
  localparam int SADDR_W    = $clog2(SLOT_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int INV_W      = 17;
  localparam int WLEN_W     = 5;
  localparam int BIN_IDX_W  = 6;
  localparam int SLOT_CNT_W = 32;
  localparam int WIN_CNT_W  = 40;
  localparam int ALL_CNT_W  = 48;
  localparam int PROD_W     = SAMPLE_W + INV_W;

  // width for slot-advance compares against the active window length
  localparam int WCMP_W     = ((SLOT_W + 1) > WLEN_W) ? (SLOT_W + 1) : WLEN_W;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_FLOOR     = 2'd0,
    CFG_ADC_CEILING   = 2'd1,
    CFG_INV_BIN_WIDTH = 2'd2,
    CFG_WINDOW_LEN    = 2'd3
  } cfg_idx_e;

  localparam logic signed [SAMPLE_W-1:0] FLOOR_RST   = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] CEILING_RST = 16'sh7FFF;
  localparam logic [INV_W-1:0]           INV_RST     = 17'h10000;
  localparam logic [WLEN_W-1:0]          WLEN_RST    = 5'd16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] adc_floor;
    logic signed [SAMPLE_W-1:0] adc_ceiling;
    logic [INV_W-1:0]           inv_bin_width;
    logic [WLEN_W-1:0]          window_len;
  } cfg_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [BIN_IDX_W-1:0]  bin_index;
    logic [WIN_CNT_W-1:0]  window_count;
    logic [ALL_CNT_W-1:0]  all_count;
    logic [WIN_CNT_W-1:0]  window_total;
    logic [ALL_CNT_W-1:0]  all_total;
    logic                  run_end;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_END   = 2'd1,
    CMD_ABORT = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [BIN_W-1:0] bin;
  } cmd_t;

endpackage

// ===== src/swah_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/swah_front.sv =====
// Front end: accepts items, finds the bin and sorts each item into a command.
// Depends on swah_pkg.
module swah_front (
  input  logic               clk,
  input  logic               rst_n,
  input  swah_pkg::cfg_t     cfg_i,
  input  logic               accept_i,
  input  swah_pkg::in_item_t item_i,
  input  logic               q_full_i,
  output logic               stall_o,
  output logic               push_o,
  output swah_pkg::cmd_t     cmd_o
);
  import swah_pkg::*;

  logic                a_valid_r, a_valid_nxt;
  in_item_t            a_item_r;
  logic                b_valid_r, b_valid_nxt;
  logic                b_kind_r, b_below_r, b_above_r;
  logic [SAMPLE_W-1:0] b_diff_r;
  logic                c_valid_r, c_valid_nxt;
  logic                c_kind_r, c_below_r, c_above_r;
  logic [PROD_W-1:0]   c_prod_r;
  logic                abort_r, abort_nxt;
  logic                advance;
  logic [INV_W-1:0]    quot;
  logic [BIN_W-1:0]    bin;

  // whole pipe moves together; it holds only when the last stage cannot push
  assign advance = !(c_valid_r && q_full_i);
  assign stall_o = !advance;

  assign quot = c_prod_r[PROD_W-1:16];
  assign bin  = (quot > INV_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : quot[BIN_W-1:0];

  always_comb begin
    a_valid_nxt = a_valid_r;
    b_valid_nxt = b_valid_r;
    c_valid_nxt = c_valid_r;
    abort_nxt   = abort_r;
    push_o      = 1'b0;
    cmd_o.op    = CMD_COUNT;
    cmd_o.bin   = bin;
    if (advance) begin
      a_valid_nxt = accept_i;
      b_valid_nxt = a_valid_r;
      c_valid_nxt = b_valid_r;
      if (c_valid_r) begin
        if (c_kind_r) begin
          push_o    = 1'b1;
          cmd_o.op  = abort_r ? CMD_ABORT : CMD_END;
          abort_nxt = 1'b0;
        end else if (!abort_r && !c_below_r) begin
          // floor test wins over the ceiling test
          if (c_above_r) begin
            abort_nxt = 1'b1;
          end else begin
            push_o = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      abort_r   <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
      abort_r   <= abort_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item_r  <= item_i;
      b_kind_r  <= a_item_r.kind;
      b_below_r <= $signed(a_item_r.sample) < $signed(cfg_i.adc_floor);
      b_above_r <= $signed(a_item_r.sample) > $signed(cfg_i.adc_ceiling);
      b_diff_r  <= SAMPLE_W'(a_item_r.sample - cfg_i.adc_floor);
      c_kind_r  <= b_kind_r;
      c_below_r <= b_below_r;
      c_above_r <= b_above_r;
      c_prod_r  <= PROD_W'(b_diff_r) * PROD_W'(cfg_i.inv_bin_width);
    end
  end

endmodule

// ===== src/swah_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on swah_pkg.
module swah_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  swah_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output swah_pkg::cmd_t head_o
);
  import swah_pkg::*;

  cmd_t                  fifo_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign head_o  = fifo_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_r[wr_ptr_r] <= cmd_i;
    end
  end

endmodule

// ===== src/swah_back.sv =====
// Back end: count memories, totals, bin report walk, slot clearing, result register.
// Depends on swah_pkg and swah_ram.
module swah_back (
  input  logic                clk,
  input  logic                rst_n,
  input  swah_pkg::cfg_t      cfg_i,
  input  swah_pkg::cmd_t      q_head_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                init_busy_o,
  input  logic                out_pop_i,
  output logic                out_empty_o,
  output swah_pkg::out_item_t out_item_o
);
  import swah_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CNT     = 8'b0000_0100,
    ST_REP_RD  = 8'b0000_1000,
    ST_REP_OUT = 8'b0001_0000,
    ST_ABT_OUT = 8'b0010_0000,
    ST_CLR_RD  = 8'b0100_0000,
    ST_CLR_WR  = 8'b1000_0000
  } state_e;

  state_e               state_r, state_nxt;
  logic [BIN_W-1:0]     bin_r, bin_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SADDR_W-1:0]   init_cnt_r, init_cnt_nxt;
  logic [WIN_CNT_W-1:0] wsum_r, wsum_nxt;
  logic [ALL_CNT_W-1:0] asum_r, asum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                  slot_we;
  logic [SADDR_W-1:0]    slot_waddr, slot_raddr;
  logic [SLOT_CNT_W-1:0] slot_wdata, slot_rdata;
  logic                  win_we;
  logic [BIN_W-1:0]      cnt_waddr, cnt_raddr;
  logic [WIN_CNT_W-1:0]  win_wdata, win_rdata;
  logic                  all_we;
  logic [ALL_CNT_W-1:0]  all_wdata, all_rdata;

  logic                  load_ok;
  logic                  last_bin;
  logic [WIN_CNT_W-1:0]  sub_val;
  logic [WCMP_W-1:0]     slot_inc, act_win;

  function automatic logic [SADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [BIN_W-1:0]  b);
    logic [SADDR_W:0] a;
    a = (SADDR_W + 1)'(s) * (SADDR_W + 1)'(NUM_BINS) + (SADDR_W + 1)'(b);
    return a[SADDR_W-1:0];
  endfunction

  assign load_ok  = !out_valid_r || out_pop_i;
  assign last_bin = (bin_r == BIN_W'(NUM_BINS - 1));
  assign sub_val  = WIN_CNT_W'(slot_rdata);

  // ring advance; window_len of zero acts as one, above the ring size as the ring size
  always_comb begin
    slot_inc = WCMP_W'(slot_r) + WCMP_W'(1);
    if (cfg_i.window_len == '0) begin
      act_win = WCMP_W'(1);
    end else if (WCMP_W'(cfg_i.window_len) > WCMP_W'(MAX_WINDOW)) begin
      act_win = WCMP_W'(MAX_WINDOW);
    end else begin
      act_win = WCMP_W'(cfg_i.window_len);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    slot_nxt      = slot_r;
    init_cnt_nxt  = init_cnt_r;
    wsum_nxt      = wsum_r;
    asum_nxt      = asum_r;
    out_valid_nxt = out_valid_r && !out_pop_i;
    out_item_nxt  = out_item_r;
    q_pop_o       = 1'b0;
    slot_we       = 1'b0;
    slot_waddr    = slot_addr(slot_r, bin_r);
    slot_wdata    = '0;
    slot_raddr    = slot_addr(slot_r, bin_r);
    win_we        = 1'b0;
    all_we        = 1'b0;
    cnt_waddr     = bin_r;
    cnt_raddr     = bin_r;
    win_wdata     = '0;
    all_wdata     = '0;

    unique case (state_r)
      ST_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = init_cnt_r;
        if ({1'b0, init_cnt_r} < (SADDR_W + 1)'(NUM_BINS)) begin
          win_we    = 1'b1;
          all_we    = 1'b1;
          cnt_waddr = init_cnt_r[BIN_W-1:0];
        end
        if (init_cnt_r == SADDR_W'(SLOT_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        // reads issued here off the queue head; data is back in ST_CNT
        slot_raddr = slot_addr(slot_r, q_head_i.bin);
        cnt_raddr  = q_head_i.bin;
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          bin_nxt = '0;
          unique case (q_head_i.op)
            CMD_COUNT: begin
              bin_nxt   = q_head_i.bin;
              state_nxt = ST_CNT;
            end
            CMD_END:   state_nxt = ST_REP_RD;
            CMD_ABORT: state_nxt = ST_ABT_OUT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CNT: begin
        slot_we    = 1'b1;
        slot_wdata = (&slot_rdata) ? slot_rdata : slot_rdata + 1'b1;
        win_we     = 1'b1;
        win_wdata  = (&win_rdata) ? win_rdata : win_rdata + 1'b1;
        all_we     = 1'b1;
        all_wdata  = (&all_rdata) ? all_rdata : all_rdata + 1'b1;
        wsum_nxt   = (&wsum_r) ? wsum_r : wsum_r + 1'b1;
        asum_nxt   = (&asum_r) ? asum_r : asum_r + 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_REP_RD: begin
        state_nxt = ST_REP_OUT;
      end
      ST_REP_OUT: begin
        if (load_ok) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = 1'b0;
          out_item_nxt.bin_index    = BIN_IDX_W'(bin_r);
          out_item_nxt.window_count = win_rdata;
          out_item_nxt.all_count    = all_rdata;
          out_item_nxt.window_total = wsum_r;
          out_item_nxt.all_total    = asum_r;
          out_item_nxt.run_end      = last_bin;
          if (last_bin) begin
            bin_nxt   = '0;
            slot_nxt  = (slot_inc >= act_win) ? '0 : slot_inc[SLOT_W-1:0];
            state_nxt = ST_CLR_RD;
          end else begin
            bin_nxt   = bin_r + 1'b1;
            state_nxt = ST_REP_RD;
          end
        end
      end
      ST_ABT_OUT: begin
        if (load_ok) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = 1'b1;
          out_item_nxt.bin_index    = '0;
          out_item_nxt.window_count = '0;
          out_item_nxt.all_count    = '0;
          out_item_nxt.window_total = wsum_r;
          out_item_nxt.all_total    = asum_r;
          out_item_nxt.run_end      = 1'b1;
          bin_nxt                   = '0;
          state_nxt                 = ST_CLR_RD;
        end
      end
      ST_CLR_RD: begin
        state_nxt = ST_CLR_WR;
      end
      ST_CLR_WR: begin
        // take the slot's count back out of the window, floored at zero
        slot_we   = 1'b1;
        win_we    = 1'b1;
        win_wdata = (win_rdata > sub_val) ? win_rdata - sub_val : '0;
        wsum_nxt  = (wsum_r > sub_val) ? wsum_r - sub_val : '0;
        if (last_bin) begin
          bin_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          state_nxt = ST_CLR_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      bin_r       <= '0;
      slot_r      <= '0;
      init_cnt_r  <= '0;
      wsum_r      <= '0;
      asum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_r       <= bin_nxt;
      slot_r      <= slot_nxt;
      init_cnt_r  <= init_cnt_nxt;
      wsum_r      <= wsum_nxt;
      asum_r      <= asum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign init_busy_o = (state_r == ST_INIT);
  assign out_empty_o = !out_valid_r;
  assign out_item_o  = out_item_r;

  swah_ram #(.WIDTH(SLOT_CNT_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  swah_ram #(.WIDTH(WIN_CNT_W), .DEPTH(NUM_BINS)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (cnt_waddr),
    .wdata (win_wdata),
    .raddr (cnt_raddr),
    .rdata (win_rdata)
  );

  swah_ram #(.WIDTH(ALL_CNT_W), .DEPTH(NUM_BINS)) u_all_ram (
    .clk   (clk),
    .we    (all_we),
    .waddr (cnt_waddr),
    .wdata (all_wdata),
    .raddr (cnt_raddr),
    .rdata (all_rdata)
  );

endmodule

// ===== src/sliding_window_adc_histogram_core.sv =====
// Top level of the sliding-window ADC histogram: config registers, front, queue, back.
// Depends on swah_pkg, swah_front, swah_cmd_fifo, swah_back.
//
//   Channel | Handshake         | Payload
//   --------+-------------------+---------------------------------
//   in      | in_push / in_full | in_item (kind, sample)
//   out     | out_pop/out_empty | out_item (status ... run_end)
//   cfg     | cfg_valid/ready   | cfg_index, cfg_data
//
// A sample runs through a three-stage front pipeline; each counted sample then
// takes the back end through ST_IDLE and ST_CNT (read-modify-write of the count memories).
// End of buffer: each bin report passes ST_REP_RD and ST_REP_OUT, then each bin of the
// oldest slot is cleared in ST_CLR_RD and ST_CLR_WR; an aborted buffer gives one status item.
// After reset a clearing pass over all MAX_WINDOW*NUM_BINS slot words holds in_full high.
// in_full also rises when the queue is full and the last front stage holds an item; a full
// result register stalls the back end directly.
module sliding_window_adc_histogram_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  swah_pkg::in_item_t                    in_item,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output swah_pkg::out_item_t                   out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swah_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swah_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import swah_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic fe_stall, fe_push, in_accept;
  logic q_full, q_empty, q_pop;
  logic init_busy;
  cmd_t fe_cmd, q_head;

  assign cfg_ready = 1'b1;
  assign in_full   = fe_stall || init_busy;
  assign in_accept = in_push && !in_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ADC_FLOOR:     cfg_nxt.adc_floor     = cfg_data[SAMPLE_W-1:0];
        CFG_ADC_CEILING:   cfg_nxt.adc_ceiling   = cfg_data[SAMPLE_W-1:0];
        CFG_INV_BIN_WIDTH: cfg_nxt.inv_bin_width = cfg_data[INV_W-1:0];
        CFG_WINDOW_LEN:    cfg_nxt.window_len    = cfg_data[WLEN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_floor     <= FLOOR_RST;
      cfg_r.adc_ceiling   <= CEILING_RST;
      cfg_r.inv_bin_width <= INV_RST;
      cfg_r.window_len    <= WLEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  swah_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg_r),
    .accept_i (in_accept),
    .item_i   (in_item),
    .q_full_i (q_full),
    .stall_o  (fe_stall),
    .push_o   (fe_push),
    .cmd_o    (fe_cmd)
  );

  swah_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fe_push),
    .cmd_i   (fe_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  swah_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .q_head_i    (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_pop_i   (out_pop),
    .out_empty_o (out_empty),
    .out_item_o  (out_item)
  );

endmodule

// ===== src/swah_checker.sv =====
// Port-level checks for the histogram core, attached by bind.
// Depends on swah_pkg and sliding_window_adc_histogram_core.
module swah_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input swah_pkg::out_item_t out_item
);
  import swah_pkg::*;

  logic                 exp_bin_vld_r;
  logic [BIN_IDX_W-1:0] exp_bin_r;
  logic [ALL_CNT_W-1:0] last_all_r;
  logic                 out_take;

  assign out_take = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bin_vld_r <= 1'b0;
      exp_bin_r     <= '0;
      last_all_r    <= '0;
    end else if (out_take) begin
      exp_bin_vld_r <= !out_item.status && !out_item.run_end;
      exp_bin_r     <= out_item.bin_index + 1'b1;
      last_all_r    <= out_item.all_total;
    end
  end

  // clearing pass keeps the input closed right after reset
  a_init_closed: assert property (@(posedge clk) $rose(rst_n) |-> in_full)
    else $error("input open during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("stalled result changed");

  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && exp_bin_vld_r |-> !out_item.status && out_item.bin_index == exp_bin_r)
    else $error("bin report out of order");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.all_total >= last_all_r)
    else $error("all-time total went down");

  a_abort_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.status |-> out_item.run_end && out_item.bin_index == '0
      && out_item.window_count == '0 && out_item.all_count == '0)
    else $error("malformed abort item");

endmodule

bind sliding_window_adc_histogram_core swah_checker u_swah_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for sliding_window_adc_histogram_core: drives sample and
// end-of-buffer items, predicts every bin report and abort status, checks each result.
// Depends on swah_pkg and the block's RTL.
module tb;
  import swah_pkg::*;

  localparam int          CLK_PERIOD    = 12;
  localparam int          RAND_ITEMS    = 200;
  localparam int          SETTLE_CYCLES = 6 * NUM_BINS;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_END     = 1'b1;
  localparam logic STATUS_BINS  = 1'b0;
  localparam logic STATUS_ABORT = 1'b1;

  // Tracks the three histograms and holds the bin reports still owed by the block.
  class histo_book;
    int                    lo_lim;
    int                    hi_lim;
    logic [INV_W-1:0]      inv;
    logic [WLEN_W-1:0]     wlen;
    logic [SLOT_CNT_W-1:0] slot_cnt [SLOT_DEPTH];
    logic [WIN_CNT_W-1:0]  win_cnt [NUM_BINS];
    logic [ALL_CNT_W-1:0]  all_cnt [NUM_BINS];
    logic [WIN_CNT_W-1:0]  win_total;
    logic [ALL_CNT_W-1:0]  all_total;
    int                    slot_idx;
    bit                    aborted;
    out_item_t             due[$];
    int                    errors;
    int                    items_seen;
    int                    items_used;
    int                    reports;
    int                    abort_runs;

    function new();
      lo_lim    = FLOOR_RST;
      hi_lim    = CEILING_RST;
      inv       = INV_RST;
      wlen      = WLEN_RST;
      foreach (slot_cnt[i]) slot_cnt[i] = '0;
      foreach (win_cnt[i]) win_cnt[i] = '0;
      foreach (all_cnt[i]) all_cnt[i] = '0;
      win_total = '0;
      all_total = '0;
      slot_idx  = 0;
      aborted   = 1'b0;
      errors    = 0;
      items_seen = 0;
      items_used = 0;
      reports    = 0;
      abort_runs = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_ADC_FLOOR:     lo_lim = $signed(d[SAMPLE_W-1:0]);
        CFG_ADC_CEILING:   hi_lim = $signed(d[SAMPLE_W-1:0]);
        CFG_INV_BIN_WIDTH: inv = d[INV_W-1:0];
        CFG_WINDOW_LEN:    wlen = d[WLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void queue_report(logic status, int bin, logic [WIN_CNT_W-1:0] wc,
                               logic [ALL_CNT_W-1:0] ac, logic last);
      out_item_t e;
      e.status       = status;
      e.bin_index    = BIN_IDX_W'(bin);
      e.window_count = wc;
      e.all_count    = ac;
      e.window_total = win_total;
      e.all_total    = all_total;
      e.run_end      = last;
      due.push_back(e);
    endfunction

    // oldest slot leaves the window; window counts never go below zero
    function void drop_slot(int s);
      logic [SLOT_CNT_W-1:0] c;
      for (int b = 0; b < NUM_BINS; b++) begin
        c = slot_cnt[s * NUM_BINS + b];
        win_cnt[b] = (win_cnt[b] > c) ? win_cnt[b] - c : '0;
        win_total  = (win_total > c) ? win_total - c : '0;
        slot_cnt[s * NUM_BINS + b] = '0;
      end
    endfunction

    function void take_item(in_item_t it);
      int     s;
      int     x;
      int     bin;
      int     span;
      longint prod;
      items_seen++;
      s = (slot_idx < MAX_WINDOW) ? slot_idx : 0;
      if (it.kind == KIND_SAMPLE) begin
        x = $signed(it.sample);
        if (aborted || x < lo_lim) return;
        items_used++;
        if (x > hi_lim) begin
          aborted = 1'b1;
          return;
        end
        prod = longint'(x - lo_lim) * longint'(inv);
        bin  = ((prod >>> 16) > NUM_BINS - 1) ? NUM_BINS - 1 : int'(prod >>> 16);
        if (slot_cnt[s * NUM_BINS + bin] != '1)
          slot_cnt[s * NUM_BINS + bin] = slot_cnt[s * NUM_BINS + bin] + 1'b1;
        if (win_cnt[bin] != '1) win_cnt[bin] = win_cnt[bin] + 1'b1;
        if (all_cnt[bin] != '1) all_cnt[bin] = all_cnt[bin] + 1'b1;
        if (win_total != '1) win_total = win_total + 1'b1;
        if (all_total != '1) all_total = all_total + 1'b1;
        return;
      end
      items_used++;
      if (aborted) begin
        // aborted buffer: one status item, slot dropped but not advanced
        queue_report(STATUS_ABORT, 0, '0, '0, 1'b1);
        drop_slot(s);
        aborted = 1'b0;
        abort_runs++;
        return;
      end
      for (int b = 0; b < NUM_BINS; b++)
        queue_report(STATUS_BINS, b, win_cnt[b], all_cnt[b], b == NUM_BINS - 1);
      span = (wlen == 0) ? 1 : (wlen > MAX_WINDOW) ? MAX_WINDOW : int'(wlen);
      s = s + 1;
      if (s >= span) s = 0;
      slot_idx = s;
      drop_slot(s);
    endfunction

    function void cmp(string name, logic [ALL_CNT_W-1:0] want, logic [ALL_CNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_report(out_item_t got);
      out_item_t want;
      reports++;
      if (due.size() == 0) begin
        $error("unexpected result item: status %0d bin_index %0d", got.status, got.bin_index);
        errors++;
        return;
      end
      want = due.pop_front();
      cmp("status", want.status, got.status);
      cmp("bin_index", want.bin_index, got.bin_index);
      cmp("window_count", want.window_count, got.window_count);
      cmp("all_count", want.all_count, got.all_count);
      cmp("window_total", want.window_total, got.window_total);
      cmp("all_total", want.all_total, got.all_total);
      cmp("run_end", want.run_end, got.run_end);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_item;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  histo_book book;
  int        in_calm;
  int        n_settings;

  sliding_window_adc_histogram_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // idle cycles before the next item; now and then a stretch with no idling
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(15) == 0) calm = $urandom_range(40, 10);
    return $urandom_range(12);
  endfunction

  // push stays high into the next item when it has no gap
  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] sample);
    in_item_t it;
    int       gap;
    it.kind   = kind;
    it.sample = sample;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    book.take_item(it);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, d);
  endtask

  // unused upper data bits are randomized; the block must ignore them
  task automatic set_regs(input int lo, input int hi, input int unsigned inv,
                          input int unsigned wlen);
    put_reg(CFG_ADC_FLOOR, {1'($urandom_range(1)), 16'(lo)});
    put_reg(CFG_ADC_CEILING, {1'($urandom_range(1)), 16'(hi)});
    put_reg(CFG_INV_BIN_WIDTH, 17'(inv));
    put_reg(CFG_WINDOW_LEN, {12'($urandom), 5'(wlen)});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // idle the input, wait out every owed result and the trailing slot clear
  task automatic settle();
    in_push <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_buffer();
    int n;
    int r;
    int lo;
    int hi;
    lo = book.lo_lim;
    hi = book.hi_lim;
    n  = ($urandom_range(7) == 0) ? $urandom_range(48) : $urandom_range(10);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 3 && hi < 32767)
        send_item(KIND_SAMPLE, 16'(hi + 1 + $urandom_range(32766 - hi)));
      else if (r < 10 && lo > -32768)
        send_item(KIND_SAMPLE, 16'(lo - 1 - $urandom_range(lo + 32767)));
      else if (r < 15 || lo > hi)
        send_item(KIND_SAMPLE, 16'($urandom));
      else
        send_item(KIND_SAMPLE, 16'(lo + $urandom_range(hi - lo)));
    end
    send_item(KIND_END, 16'($urandom));
  endtask

  initial begin : result_side
    int gap;
    int calm;
    calm = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(calm);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      book.match_report(out_item);
    end
  end

  initial begin : stimulus
    int          lo;
    int          hi;
    int          span;
    int          used_start;
    int unsigned inv;
    int unsigned wlen;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    out_pop    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ADC_FLOOR;
    cfg_data   = '0;
    in_calm    = 0;
    n_settings = 0;
    book = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: bin width of one count, so nearly everything clamps to the top bin
    send_item(KIND_SAMPLE, 16'h8000);
    send_item(KIND_SAMPLE, 16'hFFFF);
    send_item(KIND_SAMPLE, 16'h0000);
    send_item(KIND_SAMPLE, 16'h7FFF);
    send_item(KIND_END, 16'hFFFF);
    settle();

    // floor above ceiling, zero inverse width, window length 0
    set_regs(100, 50, 0, 0);
    send_item(KIND_SAMPLE, 16'(60));
    send_item(KIND_SAMPLE, 16'(200));
    send_item(KIND_SAMPLE, 16'(150));
    send_item(KIND_END, 16'h0000);
    settle();

    // abort after counts were taken, then a normal end; window length above the max
    set_regs(-50, 50, 0, 31);
    send_item(KIND_SAMPLE, 16'(-50));
    send_item(KIND_SAMPLE, 16'(50));
    send_item(KIND_SAMPLE, 16'(51));
    send_item(KIND_END, 16'h5555);
    send_item(KIND_SAMPLE, 16'(0));
    send_item(KIND_END, 16'hAAAA);
    settle();

    // walk the slot forward, then shrink the window below the slot index
    set_regs(-32768, 32767, 1024, 16);
    send_item(KIND_END, 16'h0000);
    send_item(KIND_END, 16'h0000);
    send_item(KIND_END, 16'h0000);
    send_item(KIND_SAMPLE, 16'(12345));
    send_item(KIND_END, 16'h0000);
    settle();
    set_regs(-32768, 32767, 131071, 2);
    send_item(KIND_SAMPLE, 16'(-20000));
    send_item(KIND_END, 16'h0000);
    settle();

    used_start = book.items_used;
    while (book.items_used - used_start < RAND_ITEMS) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(4))
          0: begin
            lo = -32768;
            hi = 32767;
          end
          1: begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = lo + int'($urandom_range(2000));
            if (hi > 32767) hi = 32767;
          end
          2: begin
            lo = -int'($urandom_range(500));
            hi = int'($urandom_range(500));
          end
          3: begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = int'($urandom_range(65535)) - 32768;
          end
          default: begin
            lo = -32768 + int'($urandom_range(100));
            hi = 32767 - int'($urandom_range(100));
          end
        endcase
        case ($urandom_range(3))
          0: inv = INV_RST;
          1: inv = $urandom_range(17'h1FFFF);
          2: begin
            // spread the range over roughly all bins
            span = (hi >= lo) ? hi - lo + 1 : 1;
            inv  = (NUM_BINS * 65536) / span + $urandom_range(64);
            if (inv > 17'h1FFFF) inv = 17'h1FFFF;
          end
          default: begin
            case ($urandom_range(2))
              0: inv = 0;
              1: inv = 1;
              default: inv = 17'h1FFFF;
            endcase
          end
        endcase
        case ($urandom_range(3))
          0: wlen = 1;
          1: wlen = MAX_WINDOW;
          2: wlen = $urandom_range(31);
          default: wlen = $urandom_range(4, 2);
        endcase
        set_regs(lo, hi, inv, wlen);
      end
      repeat ($urandom_range(6, 1)) send_buffer();
      settle();
    end

    $display("Sent %0d input items (%0d counted, aborting or ending a buffer) over %0d settings.",
             book.items_seen, book.items_used, n_settings);
    $display("Checked %0d result items, %0d of them aborted-buffer status; %0d mismatches.",
             book.reports, book.abort_runs, book.errors);
    if (book.errors == 0 && book.due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timeout with %0d result items still owed.", book.due.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
